[rtl/ffhs_pkg.sv]
// Shared types, widths and register codes for the fixed-length frame header sync block.
package ffhs_pkg;

   localparam int BYTE_W    = 8;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = 4;
   localparam int FLEN_W    = 6;
   localparam int HLEN_W    = 3;
   localparam int HDR_W     = 32;
   localparam int HDR_BYTES = HDR_W / BYTE_W;

   localparam logic [FLEN_W-1:0] FLEN_RST = 6'd32;
   localparam logic [HDR_W-1:0]  HDR_RST  = 32'h0000_0000;
   localparam logic [HLEN_W-1:0] HLEN_RST = 3'd1;

   typedef enum logic [1:0] {
      REG_FRAME_LENGTH  = 2'd0,
      REG_HEADER_BYTES  = 2'd1,
      REG_HEADER_LENGTH = 2'd2
   } reg_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctrl_type;

   // Header byte k of the pattern; bytes past the register compare against zero.
   function automatic logic [BYTE_W-1:0] pattern_byte(input logic [HDR_W-1:0] hdr,
                                                      input int k);
      logic [BYTE_W-1:0] b;
      b = '0;
      if (k < HDR_BYTES) begin
         b = hdr[k*BYTE_W +: BYTE_W];
      end
      return b;
   endfunction

endpackage

[rtl/ffhs_cell.sv]
// One window cell: holds a byte, loads a new one or takes its upper neighbor's byte.
module ffhs_cell (
   input  logic                          clock,
   input  ffhs_pkg::cell_ctrl_type       ctrl,
   input  logic [ffhs_pkg::BYTE_W-1:0]   load_byte,
   input  logic [ffhs_pkg::BYTE_W-1:0]   next_byte,
   output logic [ffhs_pkg::BYTE_W-1:0]   data
);
   import ffhs_pkg::*;

   logic [BYTE_W-1:0] data_ff;
   logic [BYTE_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.load) begin
         data_in = load_byte;
      end else if (ctrl.shift) begin
         data_in = next_byte;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[rtl/fixed_frame_header_sync.sv]
// Fixed-length frame header sync: a row of byte cells, oldest byte in cell 0.
// A request that leaves the window short of frame_length is taken without a stall.
// A request that fills it stalls the input: a scan that drops the oldest byte per step
// (one cell shift each) until the header is at the head or the window runs short, or a check
// plus the output of frame_length bytes when aligned; output stretches with rsp_stall.
// Synchronous reset empties the window; frame_length 32, header_bytes 0, header_length 1.
module fixed_frame_header_sync #(
   parameter int MAX_FRAME  = 32,
   parameter int MAX_HEADER = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ffhs_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ffhs_pkg::BYTE_W-1:0]   rsp_frame_byte,
   output logic                          rsp_frame_last,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [ffhs_pkg::ADDR_W-1:0]   csr_paddr,
   input  logic [ffhs_pkg::DATA_W-1:0]   csr_pwdata,
   output logic [ffhs_pkg::DATA_W-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import ffhs_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam int HL_W  = $clog2(MAX_HEADER + 1);
   localparam int CMP_N = (MAX_HEADER < MAX_FRAME) ? MAX_HEADER : MAX_FRAME;

   logic [FLEN_W-1:0] frame_length_ff;
   logic [HDR_W-1:0]  header_bytes_ff;
   logic [HLEN_W-1:0] header_length_ff;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              dropped_ff, dropped_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff;
   logic              rsp_last_ff;

   logic              cfg_wr;
   reg_idx_type       reg_idx;
   logic [CNT_W-1:0]  eff_fl;
   logic [HL_W-1:0]   hl_sel;
   logic [CNT_W-1:0]  hl_eff;
   logic              req_accept;
   logic              head_match;
   logic              enough;
   logic              emit_go;
   logic              scan_shift;

   logic [BYTE_W-1:0] cell_data [MAX_FRAME];
   cell_ctrl_type     cell_ctrl [MAX_FRAME];

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign reg_idx    = reg_idx_type'(csr_paddr[3:2]);
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_length_ff  <= FLEN_RST;
         header_bytes_ff  <= HDR_RST;
         header_length_ff <= HLEN_RST;
      end else if (cfg_wr) begin
         unique case (reg_idx)
            REG_FRAME_LENGTH:  frame_length_ff  <= csr_pwdata[FLEN_W-1:0];
            REG_HEADER_BYTES:  header_bytes_ff  <= csr_pwdata[HDR_W-1:0];
            REG_HEADER_LENGTH: header_length_ff <= csr_pwdata[HLEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_FRAME_LENGTH:  csr_prdata = DATA_W'(frame_length_ff);
         REG_HEADER_BYTES:  csr_prdata = DATA_W'(header_bytes_ff);
         REG_HEADER_LENGTH: csr_prdata = DATA_W'(header_length_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // ---------------- effective lengths ----------------
   always_comb begin
      if (frame_length_ff == '0) begin
         eff_fl = CNT_W'(1);
      end else if (32'(frame_length_ff) > MAX_FRAME) begin
         eff_fl = CNT_W'(MAX_FRAME);
      end else begin
         eff_fl = CNT_W'(frame_length_ff);
      end

      if (header_length_ff == '0) begin
         hl_sel = HL_W'(1);
      end else if (32'(header_length_ff) > MAX_HEADER) begin
         hl_sel = HL_W'(MAX_HEADER);
      end else begin
         hl_sel = HL_W'(header_length_ff);
      end

      // clamp header to frame length
      if (32'(hl_sel) > 32'(eff_fl)) begin
         hl_eff = eff_fl;
      end else begin
         hl_eff = CNT_W'(hl_sel);
      end
   end

   // ---------------- header compare at the head of the window ----------------
   always_comb begin
      head_match = 1'b1;
      for (int k = 0; k < CMP_N; k++) begin
         if (k < int'(hl_eff) && cell_data[k] != pattern_byte(header_bytes_ff, k)) begin
            head_match = 1'b0;
         end
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign enough     = (fill_ff >= hl_eff);
   assign emit_go    = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign scan_shift = (state_ff == ST_SCAN) && enough && !head_match;

   // ---------------- cell row ----------------
   for (genvar i = 0; i < MAX_FRAME; i++) begin : g_cell
      logic [BYTE_W-1:0] next_byte;

      if (i == MAX_FRAME - 1) begin : g_tail
         assign next_byte = '0;
      end else begin : g_body
         assign next_byte = cell_data[i+1];
      end

      assign cell_ctrl[i].load  = req_accept && (fill_ff == CNT_W'(i));
      assign cell_ctrl[i].shift = scan_shift || emit_go;

      ffhs_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[i]),
         .load_byte (req_rx_byte),
         .next_byte (next_byte),
         .data      (cell_data[i])
      );
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      dropped_in = dropped_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               fill_in = fill_ff + CNT_W'(1);
               if (fill_ff + CNT_W'(1) == eff_fl) begin
                  state_in   = ST_SCAN;
                  dropped_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (!enough) begin
               // no full header left: the newest hl_eff-1 bytes stay
               state_in = ST_IDLE;
            end else if (head_match) begin
               state_in = dropped_ff ? ST_IDLE : ST_EMIT;
            end else begin
               // drop the oldest byte and try the next offset
               fill_in    = fill_ff - CNT_W'(1);
               dropped_in = 1'b1;
            end
         end
         ST_EMIT: begin
            if (emit_go) begin
               fill_in = fill_ff - CNT_W'(1);
               if (fill_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a new frame length empties the window
      if (cfg_wr && reg_idx == REG_FRAME_LENGTH) begin
         fill_in  = '0;
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         dropped_ff <= dropped_in;
      end
   end

   // ---------------- output register ----------------
   assign rsp_valid_in = emit_go || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_go) begin
         rsp_byte_ff <= cell_data[0];
         rsp_last_ff <= (fill_ff == CNT_W'(1));
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_frame_last = rsp_last_ff;

`ifndef SYNTH
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= eff_fl)
      else $error("window fill exceeds frame length");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT |-> fill_ff != '0)
      else $error("emitting from an empty window");

   a_scan_progress: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && $past(state_ff == ST_SCAN)) |-> fill_ff < $past(fill_ff))
      else $error("header scan did not advance");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_EMIT))
      else $error("response raised outside frame output");
`endif

endmodule
